// ===== rtl/core/fed_pkg.sv =====
// Shared types and constants for the feedback echo delay core.
// Used by the ring memory, mix datapath, output queue and top level.
package fed_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 8;
  localparam int DELAY_W   = 17;
  localparam int CFG_IDX_W = 4;
  localparam int OQ_DEPTH  = 3;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd64;
  localparam logic [GAIN_W-1:0]  MIX_ONE     = 8'd128;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd48000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEEDBACK_GAIN = 4'd0,
    CFG_DELAY_SAMPLES = 4'd1
  } cfg_idx_t;

  typedef struct packed {
    logic    re;
    logic    we;
    sample_t wdata;
  } mem_ctl_t;

  typedef struct packed {
    logic [1:0] count;
  } oq_status_t;

endpackage

// ===== rtl/core/fed_ring_mem.sv =====
// Single-clock ring memory holding the delay line samples.
// One write and one registered read per cycle; uses fed_pkg.
module fed_ring_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                clk,
  input  fed_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       waddr,
  input  logic [AW-1:0]       raddr,
  output fed_pkg::sample_t    rdata
);

  fed_pkg::sample_t mem [DEPTH];
  fed_pkg::sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fed_mix.sv =====
// Feedback mix datapath: live*128 + (stored-live)*gain, scaled by 1/128
// toward zero and clamped to 16 bits. Uses fed_pkg constants.
module fed_mix (
  input  fed_pkg::sample_t                 stored,
  input  fed_pkg::sample_t                 live,
  input  logic [fed_pkg::GAIN_W-1:0]       gain,
  output fed_pkg::sample_t                 mix
);

  logic [fed_pkg::GAIN_W-1:0] g;
  logic signed [16:0]         diff;
  logic signed [25:0]         prod;
  logic signed [25:0]         acc;
  logic signed [25:0]         adj;
  logic signed [18:0]         quo;

  always_comb begin
    g    = (gain > fed_pkg::MIX_ONE) ? fed_pkg::MIX_ONE : gain;
    diff = 17'(stored) - 17'(live);
    prod = 26'(diff) * $signed({18'd0, g});
    acc  = (26'(live) <<< 7) + prod;
    adj  = acc[25] ? (acc + 26'sd127) : acc;
    quo  = 19'(adj >>> 7);
    if (quo > 19'(fed_pkg::SAMPLE_MAX)) begin
      mix = fed_pkg::SAMPLE_MAX;
    end else if (quo < 19'(fed_pkg::SAMPLE_MIN)) begin
      mix = fed_pkg::SAMPLE_MIN;
    end else begin
      mix = quo[15:0];
    end
  end

endmodule

// ===== rtl/core/fed_out_fifo.sv =====
// Small output queue that decouples the pipeline from the result consumer.
// Three entries; uses fed_pkg types.
module fed_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  fed_pkg::sample_t       push_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,    // [15:0] out_sample
  output fed_pkg::oq_status_t    status
);

  fed_pkg::sample_t buf_r [fed_pkg::OQ_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(fed_pkg::OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(fed_pkg::OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign status.count = count_r;

endmodule

// ===== rtl/core/feedback_echo_delay_core.sv =====
// Feedback echo delay core: ring memory read-modify-write per sample.
// Requests go via the s1_* registers and the output queue to out_tvalid;
// throughput one request per cycle while in_tready is high, set by the
// single ring memory read and write-back. Reset (sync, rst_n low) clears
// position and fill count; unwritten ring entries read as silence, so no
// clearing pass is needed. A delay_samples write does the same.
module feedback_echo_delay_core #(
  parameter int MAX_DELAY_SAMPLES = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] in_sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] out_sample
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fed_pkg::DELAY_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_DELAY_SAMPLES);
  localparam int FW = $clog2(MAX_DELAY_SAMPLES + 1);
  localparam int CW = (FW > fed_pkg::DELAY_W) ? FW : fed_pkg::DELAY_W;

  logic [fed_pkg::GAIN_W-1:0]  gain_r;
  logic [fed_pkg::DELAY_W-1:0] delay_r;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;

  logic                        s1_valid_r;
  logic                        s1_bypass_r;
  logic                        s1_fwd_r;
  logic                        s1_zero_r;
  fed_pkg::sample_t            s1_live_r;
  fed_pkg::sample_t            s1_fwd_data_r;
  logic [AW-1:0]               s1_addr_r;

  logic                        accept;
  logic                        bypass;
  logic                        rd_issue;
  logic [CW-1:0]               delay_w;
  logic [FW-1:0]               len;
  logic [FW-1:0]               pos_inc;
  logic [FW-1:0]               waddr_inc;
  fed_pkg::sample_t            rdata;
  fed_pkg::sample_t            stored;
  fed_pkg::sample_t            mix;
  fed_pkg::mem_ctl_t           mem_ctl;
  fed_pkg::oq_status_t         oq_status;
  logic                        push;
  fed_pkg::sample_t            push_data;
  logic                        cfg_we;
  logic                        cfg_gain_we;
  logic                        cfg_delay_we;

  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign cfg_gain_we  = cfg_we && (cfg_index == fed_pkg::CFG_FEEDBACK_GAIN);
  assign cfg_delay_we = cfg_we && (cfg_index == fed_pkg::CFG_DELAY_SAMPLES);

  assign in_tready = (3'(oq_status.count) + 3'(s1_valid_r)) < 3'(fed_pkg::OQ_DEPTH);
  assign accept    = in_tvalid && in_tready;
  assign bypass    = (gain_r == '0);
  assign rd_issue  = accept && !bypass;

  always_comb begin
    delay_w = CW'(delay_r);
    if (delay_r == '0) begin
      len = FW'(1);
    end else if (delay_w > CW'(MAX_DELAY_SAMPLES)) begin
      len = FW'(MAX_DELAY_SAMPLES);
    end else begin
      len = FW'(delay_w);
    end
    pos_inc = FW'(pos_r) + FW'(1);
    pos_nxt = (pos_inc >= len) ? '0 : AW'(pos_inc);
  end

  always_comb begin
    if (s1_fwd_r) begin
      stored = s1_fwd_data_r;
    end else if (s1_zero_r) begin
      stored = '0;
    end else begin
      stored = rdata;
    end
  end

  fed_mix u_mix (
    .stored (stored),
    .live   (s1_live_r),
    .gain   (gain_r),
    .mix    (mix)
  );

  assign mem_ctl.re    = rd_issue;
  assign mem_ctl.we    = s1_valid_r && !s1_bypass_r;
  assign mem_ctl.wdata = mix;

  assign waddr_inc = FW'(s1_addr_r) + FW'(1);
  assign fill_nxt  = (mem_ctl.we && (waddr_inc > fill_r)) ? waddr_inc : fill_r;

  fed_ring_mem #(
    .DEPTH (MAX_DELAY_SAMPLES),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (s1_addr_r),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign push      = s1_valid_r;
  assign push_data = s1_bypass_r ? s1_live_r : stored;

  fed_out_fifo u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (oq_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= fed_pkg::GAIN_RESET;
      delay_r    <= fed_pkg::DELAY_RESET;
      pos_r      <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (cfg_gain_we) begin
        gain_r <= cfg_data[fed_pkg::GAIN_W-1:0];
      end
      if (cfg_delay_we) begin
        delay_r <= cfg_data;
        pos_r   <= '0;
        fill_r  <= '0;
      end else begin
        fill_r <= fill_nxt;
        if (rd_issue) begin
          pos_r <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bypass_r   <= bypass;
      s1_live_r     <= in_tdata;
      s1_addr_r     <= pos_r;
      s1_fwd_r      <= mem_ctl.we && (s1_addr_r == pos_r);
      s1_fwd_data_r <= mix;
      s1_zero_r     <= (FW'(pos_r) >= fill_r);
    end
  end

endmodule

// ===== dv/feedback_echo_delay_checker.sv =====
// Checker for the feedback echo delay core: tracks register writes and sample
// requests, predicts each delayed sample and compares it on the result channel.
// Depends on fed_pkg for widths, register indexes and reset values.
module feedback_echo_delay_checker #(
  parameter int MAX_DELAY_SAMPLES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [15:0]                   out_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fed_pkg::DELAY_W-1:0]   cfg_data,
  output int                            mismatch_count,
  output int                            echoes_due
);
  import fed_pkg::*;

  sample_t            echo_line [int];
  int                 ring_pos;
  logic [GAIN_W-1:0]  gain_reg;
  logic [DELAY_W-1:0] length_reg;
  sample_t            echo_queue [$];
  int                 errors;

  function automatic sample_t predict_echo(input sample_t live);
    int      g;
    int      len;
    int      pos;
    int      mixed;
    sample_t stored;
    if (gain_reg == '0) return live;
    g = (gain_reg > MIX_ONE) ? int'(MIX_ONE) : int'(gain_reg);
    if (length_reg == '0) len = 1;
    else if (length_reg > MAX_DELAY_SAMPLES) len = MAX_DELAY_SAMPLES;
    else len = int'(length_reg);
    pos = (ring_pos >= len) ? 0 : ring_pos;
    stored = echo_line.exists(pos) ? echo_line[pos] : '0;
    mixed = (int'(stored) * g + int'(live) * (int'(MIX_ONE) - g)) / int'(MIX_ONE);
    if (mixed > int'(SAMPLE_MAX)) mixed = int'(SAMPLE_MAX);
    if (mixed < int'(SAMPLE_MIN)) mixed = int'(SAMPLE_MIN);
    echo_line[pos] = sample_t'(mixed);
    ring_pos = (pos + 1 >= len) ? 0 : pos + 1;
    return stored;
  endfunction

  always @(posedge clk) begin : watch
    sample_t want;
    if (!rst_n) begin
      echo_line.delete();
      echo_queue.delete();
      ring_pos   = 0;
      gain_reg   = GAIN_RESET;
      length_reg = DELAY_RESET;
      errors     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (echo_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected out_sample %0d", $signed(out_tdata));
        end else begin
          want = echo_queue.pop_front();
          if (out_tdata !== want) begin
            errors++;
            if (errors <= 10)
              $display("out_sample mismatch: expected %0d, got %0d", want,
                       $signed(out_tdata));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FEEDBACK_GAIN: gain_reg = cfg_data[GAIN_W-1:0];
          CFG_DELAY_SAMPLES: begin
            length_reg = cfg_data;
            echo_line.delete();
            ring_pos = 0;
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) echo_queue.push_back(predict_echo(sample_t'(in_tdata)));
    end
    mismatch_count <= errors;
    echoes_due     <= echo_queue.size();
  end

endmodule

// ===== dv/feedback_echo_delay_core_tb.sv =====
// Testbench top for feedback_echo_delay_core: clock, reset, sample and register
// stimulus with random idling and a long result hold-off, verdict at the end.
// Depends on fed_pkg, the core and feedback_echo_delay_checker.
module feedback_echo_delay_core_tb;
  import fed_pkg::*;

  localparam int MAX_RING      = 65536;
  localparam int MIX_SETTINGS  = 8;
  localparam int ITEMS_PER_MIX = 175;
  localparam int SINK_HOLD     = 64;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DELAY_W-1:0]   cfg_data   = '0;
  bit                   idle_on    = 1'b1;
  int                   hold_asks  = 0;
  int                   mismatch_count;
  int                   echoes_due;

  always #1 clk = ~clk;

  feedback_echo_delay_core #(.MAX_DELAY_SAMPLES(MAX_RING)) u_dut (.*);

  feedback_echo_delay_checker #(.MAX_DELAY_SAMPLES(MAX_RING)) u_chk (.*);

  task automatic send_sample(input sample_t s);
    while (idle_on && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (echoes_due != 0);
  endtask

  task automatic reconfigure(input bit set_gain, input logic [DELAY_W-1:0] gain_val,
                             input bit set_len, input logic [DELAY_W-1:0] len_val);
    drain();
    if (set_gain) write_reg(CFG_FEEDBACK_GAIN, gain_val);
    if (set_len) write_reg(CFG_DELAY_SAMPLES, len_val);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(15))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : sink
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served = hold_asks;
        out_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 9);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [DELAY_W-1:0] gain_val;
    logic [DELAY_W-1:0] len_val;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    reconfigure(1'b1, 17'd1, 1'b1, 17'd2);
    repeat (2) begin
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
    end
    reconfigure(1'b1, 17'd127, 1'b0, '0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample('0);
    send_sample('0);
    // drop upper data bits: gain lands on 128
    reconfigure(1'b1, 17'h1ff80, 1'b0, '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sh5a5a);
    reconfigure(1'b1, 17'd200, 1'b0, '0);
    send_sample(16'sh7f00);
    send_sample(-16'sh1234);
    reconfigure(1'b1, 17'd0, 1'b0, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sh1234);
    drain();
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_FEEDBACK_GAIN, 17'd64);
    write_reg(CFG_DELAY_SAMPLES, 17'd0);
    cfg_valid <= 1'b0;
    repeat (2) begin
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
    end
    reconfigure(1'b0, '0, 1'b1, 17'h1ffff);
    send_sample(16'sh4321);
    send_sample(16'sh0001);
    reconfigure(1'b0, '0, 1'b1, 17'd65536);
    send_sample(-16'sd1);

    for (int m = 0; m < MIX_SETTINGS; m++) begin
      case ($urandom_range(7))
        0: gain_val = 17'd128;
        1: gain_val = DELAY_W'($urandom_range(255, 129));
        2: gain_val = 17'd1;
        3: gain_val = 17'd127;
        default: gain_val = DELAY_W'($urandom_range(127, 1));
      endcase
      if (m == 5) gain_val = '0;
      case ($urandom_range(9))
        0: len_val = '0;
        1: len_val = DELAY_W'($urandom_range(4000, 49));
        default: len_val = DELAY_W'($urandom_range(48, 1));
      endcase
      reconfigure(1'b1, gain_val, m == 0 || $urandom_range(3) != 0, len_val);
      idle_on <= (m != 3);
      for (int k = 0; k < ITEMS_PER_MIX; k++) begin
        if (m == 2 && k == 60) hold_asks <= hold_asks + 1;
        send_sample(pick_sample());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
